### sv/lpp_pkg.sv
// shared types and constants for the look-at perspective point projector
package lpp_pkg;

    // default screen size
    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    // field and datapath widths
    localparam int CW = 16;  // coordinate and register width, Q10.6
    localparam int PW = 17;  // point minus camera, Q.6
    localparam int BW = 16;  // basis component width, Q1.15
    localparam int FW = 8;   // focal length width

    // basis saturation bound
    localparam logic signed [BW-1:0] BASIS_MAX = 16'sd32767;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CAMERA_X     = 3'd0,
        CFG_CAMERA_Y     = 3'd1,
        CFG_CAMERA_Z     = 3'd2,
        CFG_TARGET_X     = 3'd3,
        CFG_TARGET_Y     = 3'd4,
        CFG_TARGET_Z     = 3'd5,
        CFG_FOCAL_LENGTH = 3'd6
    } t_cfg_idx;

    // camera position and look-at target
    typedef struct packed {
        logic signed [CW-1:0] cam_x;
        logic signed [CW-1:0] cam_y;
        logic signed [CW-1:0] cam_z;
        logic signed [CW-1:0] tgt_x;
        logic signed [CW-1:0] tgt_y;
        logic signed [CW-1:0] tgt_z;
    } t_cam;

    // camera basis, right has no y component
    typedef struct packed {
        logic signed [BW-1:0] fx;
        logic signed [BW-1:0] fy;
        logic signed [BW-1:0] fz;
        logic signed [BW-1:0] rx;
        logic signed [BW-1:0] rz;
        logic signed [BW-1:0] ux;
        logic signed [BW-1:0] uy;
        logic signed [BW-1:0] uz;
    } t_basis;

endpackage

### sv/lpp_basis.sv
// sequential camera basis builder: squares, bit-serial root, bit-serial divide
module lpp_basis (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_restart,
    input  lpp_pkg::t_cam  i_cam,
    output logic           o_busy,
    output lpp_pkg::t_basis o_basis
);
    import lpp_pkg::*;

    localparam int SW   = 34;          // sum of squares
    localparam int RADW = SW + 20;     // radicand
    localparam int ROW  = RADW / 2;    // root width
    localparam int NUMW = PW + 25;     // divide numerator
    localparam int QW   = BW - 1;      // quotient bits before saturation
    localparam int MPW  = 2 * PW;      // product width
    localparam int UW   = MPW + 1;     // up component sum width
    localparam logic [SW-1:0] RIGHT_MIN_SQ = SW'(1073);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SQMUL  = 9'b000000010,
        ST_SQSUM  = 9'b000000100,
        ST_ROOT   = 9'b000001000,
        ST_DLOAD  = 9'b000010000,
        ST_DIV    = 9'b000100000,
        ST_DSTORE = 9'b001000000,
        ST_UPMUL  = 9'b010000000,
        ST_UPSUM  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_right, n_right;
    logic [1:0] r_comp, n_comp;
    logic [4:0] r_cnt, n_cnt;
    logic signed [MPW-1:0] r_prod [4];
    logic [RADW-1:0] r_rad, n_rad;
    logic [RADW-1:0] r_res, n_res;
    logic [RADW-1:0] r_bit, n_bit;
    logic [ROW-1:0]  r_root, n_root;
    logic [NUMW-1:0] r_rem, n_rem;
    logic [QW-1:0]   r_q, n_q;
    logic            r_neg, n_neg;
    t_basis          r_b, n_b;

    logic signed [PW-1:0]  w_dx, w_dy, w_dz;
    logic signed [PW-1:0]  w_ma [4];
    logic signed [PW-1:0]  w_mb [4];
    logic signed [MPW-1:0] w_prod [4];
    logic [SW-1:0]         w_sum;
    logic [RADW:0]         w_rtry;
    logic signed [PW-1:0]  w_num_a;
    logic [PW-1:0]         w_mag;
    logic [NUMW-1:0]       w_num;
    logic [NUMW-1:0]       w_dfull;
    logic [NUMW-1:0]       w_dsh;
    logic signed [BW-1:0]  w_qval;
    logic signed [UW-1:0]  w_u [3];
    logic signed [BW-1:0]  w_usat [3];

    // look direction before normalizing
    assign w_dx = PW'(i_cam.tgt_x) - PW'(i_cam.cam_x);
    assign w_dy = PW'(i_cam.tgt_y) - PW'(i_cam.cam_y);
    assign w_dz = PW'(i_cam.tgt_z) - PW'(i_cam.cam_z);

    // shared multipliers: squares for lengths, cross products for up
    always_comb begin
        w_ma[0] = w_dx; w_mb[0] = w_dx;
        w_ma[1] = w_dy; w_mb[1] = w_dy;
        w_ma[2] = w_dz; w_mb[2] = w_dz;
        w_ma[3] = '0;   w_mb[3] = '0;
        if (r_state == ST_UPMUL) begin
            w_ma[0] = PW'(r_b.rz); w_mb[0] = PW'(r_b.fy);
            w_ma[1] = PW'(r_b.rz); w_mb[1] = PW'(r_b.fx);
            w_ma[2] = PW'(r_b.rx); w_mb[2] = PW'(r_b.fz);
            w_ma[3] = PW'(r_b.rx); w_mb[3] = PW'(r_b.fy);
        end else if (r_right) begin
            w_ma[0] = PW'(r_b.fx); w_mb[0] = PW'(r_b.fx);
            w_ma[1] = PW'(r_b.fz); w_mb[1] = PW'(r_b.fz);
            w_ma[2] = '0;          w_mb[2] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            w_prod[i] = w_ma[i] * w_mb[i];
        end
    end

    assign w_sum = SW'(unsigned'(r_prod[0])) + SW'(unsigned'(r_prod[1]))
                 + SW'(unsigned'(r_prod[2]));

    // one root digit per cycle
    assign w_rtry = {1'b0, r_res} + {1'b0, r_bit};

    // component to normalize
    always_comb begin
        w_num_a = w_dx;
        if (r_right) begin
            case (r_comp)
                2'd0:    w_num_a = -PW'(r_b.fz);
                default: w_num_a = PW'(r_b.fx);
            endcase
        end else begin
            case (r_comp)
                2'd0:    w_num_a = w_dx;
                2'd1:    w_num_a = w_dy;
                default: w_num_a = w_dz;
            endcase
        end
    end

    assign w_mag   = w_num_a[PW-1] ? PW'(-w_num_a) : PW'(w_num_a);
    assign w_num   = {w_mag, 25'b0};
    assign w_dfull = {r_root, 15'b0};
    assign w_dsh   = NUMW'(r_root) << r_cnt[3:0];
    assign w_qval  = r_neg ? -BW'(signed'({1'b0, r_q})) : BW'(signed'({1'b0, r_q}));

    // up components, divided by 2^15 toward zero and saturated
    always_comb begin
        w_u[0] = -UW'(r_prod[0]);
        w_u[1] = UW'(r_prod[1]) - UW'(r_prod[2]);
        w_u[2] = UW'(r_prod[3]);
        for (int i = 0; i < 3; i++) begin
            if (w_u[i] < 0) begin
                w_u[i] = (w_u[i] + UW'(32767)) >>> 15;
            end else begin
                w_u[i] = w_u[i] >>> 15;
            end
            if (w_u[i] > UW'(BASIS_MAX)) begin
                w_usat[i] = BASIS_MAX;
            end else if (w_u[i] < -UW'(BASIS_MAX)) begin
                w_usat[i] = -BASIS_MAX;
            end else begin
                w_usat[i] = BW'(w_u[i]);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_right = r_right;
        n_comp  = r_comp;
        n_cnt   = r_cnt;
        n_rad   = r_rad;
        n_res   = r_res;
        n_bit   = r_bit;
        n_root  = r_root;
        n_rem   = r_rem;
        n_q     = r_q;
        n_neg   = r_neg;
        n_b     = r_b;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_SQMUL: begin
                n_state = ST_SQSUM;
            end
            ST_SQSUM: begin
                n_rad  = {w_sum, 20'b0};
                n_res  = '0;
                n_bit  = RADW'(1) << (RADW - 2);
                n_cnt  = 5'(ROW - 1);
                n_comp = '0;
                if (!r_right) begin
                    if (w_sum == '0) begin
                        n_b.fx  = '0;
                        n_b.fy  = '0;
                        n_b.fz  = BASIS_MAX;
                        n_right = 1'b1;
                        n_state = ST_SQMUL;
                    end else begin
                        n_state = ST_ROOT;
                    end
                end else if (w_sum > RIGHT_MIN_SQ) begin
                    n_state = ST_ROOT;
                end else begin
                    n_b.rx  = -r_b.fz;
                    n_b.rz  = r_b.fx;
                    n_state = ST_UPMUL;
                end
            end
            ST_ROOT: begin
                if ({1'b0, r_rad} >= w_rtry) begin
                    n_rad = r_rad - RADW'(w_rtry);
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_root  = n_res[ROW-1:0];
                    n_state = ST_DLOAD;
                end
            end
            ST_DLOAD: begin
                n_neg = w_num_a[PW-1];
                n_rem = w_num;
                n_q   = '0;
                n_cnt = 5'(QW - 1);
                if (w_num >= w_dfull) begin
                    n_q     = '1;
                    n_state = ST_DSTORE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_rem >= w_dsh) begin
                    n_rem = r_rem - w_dsh;
                    n_q   = {r_q[QW-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[QW-2:0], 1'b0};
                end
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = ST_DSTORE;
                end
            end
            ST_DSTORE: begin
                n_comp  = r_comp + 2'd1;
                n_state = ST_DLOAD;
                if (!r_right) begin
                    case (r_comp)
                        2'd0:    n_b.fx = w_qval;
                        2'd1:    n_b.fy = w_qval;
                        default: n_b.fz = w_qval;
                    endcase
                    if (r_comp == 2'd2) begin
                        n_right = 1'b1;
                        n_state = ST_SQMUL;
                    end
                end else begin
                    case (r_comp)
                        2'd0:    n_b.rx = w_qval;
                        default: n_b.rz = w_qval;
                    endcase
                    if (r_comp == 2'd1) begin
                        n_state = ST_UPMUL;
                    end
                end
            end
            ST_UPMUL: begin
                n_state = ST_UPSUM;
            end
            ST_UPSUM: begin
                n_b.ux  = w_usat[0];
                n_b.uy  = w_usat[1];
                n_b.uz  = w_usat[2];
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_restart) begin
            n_state = ST_SQMUL;
            n_right = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SQMUL;
            r_right <= 1'b0;
        end else begin
            r_state <= n_state;
            r_right <= n_right;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_comp <= n_comp;
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_res  <= n_res;
        r_bit  <= n_bit;
        r_root <= n_root;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_neg  <= n_neg;
        r_b    <= n_b;
        for (int i = 0; i < 4; i++) begin
            r_prod[i] <= w_prod[i];
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_basis = r_b;

endmodule

### sv/lookat_perspective_point_projector_unit.sv
// top level: config registers, basis builder and the per-item projection pipeline
//
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+------------------------------
//  item in  | i_point_x, i_point_y, i_point_z            | i_start & ~o_busy
//  result   | o_screen_x, o_screen_y, o_visible          | o_done, one-cycle strobe
//  config   | i_cfg_index, i_cfg_data                    | i_cfg_valid & o_cfg_ready
//
// one item per cycle while o_busy is low; each item is registered as the relative point,
// then the basis products, dot products, perspective numerators, biased magnitudes, range
// check, the per-stage restoring divide with quotient width QB (7 for a 128x64 screen) and
// the result; after reset and after each config write the camera basis is rebuilt by a
// sequential unit (square root and divides one bit per cycle); o_busy is high for that time
// and no item is taken; the result side cannot stall, so the pipeline never holds
module lookat_perspective_point_projector_unit #(
    parameter int SCREEN_WIDTH  = lpp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = lpp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic signed [15:0]        i_point_x,
    input  logic signed [15:0]        i_point_y,
    input  logic signed [15:0]        i_point_z,
    output logic                      o_done,
    output logic [6:0]                o_screen_x,
    output logic [5:0]                o_screen_y,
    output logic                      o_visible,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [2:0]                i_cfg_index,
    input  logic [15:0]               i_cfg_data
);
    import lpp_pkg::*;

    localparam int HW = SCREEN_WIDTH / 2;
    localparam int HH = SCREEN_HEIGHT / 2;
    localparam int MX = (SCREEN_WIDTH - HW > HW + 1) ? SCREEN_WIDTH - HW : HW + 1;
    localparam int MY = (SCREEN_HEIGHT - HH > HH + 1) ? SCREEN_HEIGHT - HH : HH + 1;
    localparam int QB = $clog2((MX > MY) ? MX : MY);
    localparam int MPW = PW + BW;       // product
    localparam int TW  = MPW + 2;       // camera-space coordinate
    localparam int NW  = TW + FW + 1;   // coordinate times focal length
    localparam int MW  = NW + 1;        // biased magnitude
    localparam int SXW = 10;            // screen coordinate before masking

    typedef struct packed {
        logic [MW-1:0] rem;
        logic [QB-1:0] q;
        logic          neg;
        logic          ovf;
    } t_lane;

    // config registers
    t_cam        r_cam;
    logic [FW-1:0] r_focal;
    logic        w_cfg_we;
    t_cfg_idx    w_cfg_idx;

    // basis
    logic        w_basis_busy;
    t_basis      w_b;

    // pipeline
    logic                  r_v0, r_v1, r_v2, r_v3, r_v4;
    logic signed [PW-1:0]  r_px, r_py, r_pz;
    logic signed [MPW-1:0] r_m [8];
    logic signed [TW-1:0]  r_tx, r_ty, r_tz;
    logic signed [NW-1:0]  r_nx, r_ny;
    logic [TW-1:0]         r_d3, r_d4;
    logic                  r_pos3, r_pos4;
    logic [MW-1:0]         r_mx, r_my;
    logic                  r_negx, r_negy;
    logic                  r_dv  [QB+1];
    logic [TW-1:0]         r_dd  [QB+1];
    logic                  r_dpos[QB+1];
    t_lane                 r_lx  [QB+1];
    t_lane                 r_ly  [QB+1];
    t_lane                 n_lx  [QB+1];
    t_lane                 n_ly  [QB+1];
    logic                  r_done, r_vis;
    logic [6:0]            r_sx;
    logic [5:0]            r_sy;

    logic                  w_accept;
    logic [MW-1:0]         w_dk;
    logic [QB-1:0]         w_qx, w_qy;
    logic                  w_inx, w_iny, w_vis;
    logic [SXW-1:0]        w_sx, w_sy;
    logic [NW-1:0]         w_magx, w_magy;

    // config port
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;
    assign w_cfg_idx   = t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam.cam_x <= '0;
            r_cam.cam_y <= '0;
            r_cam.cam_z <= 16'sd9600;
            r_cam.tgt_x <= '0;
            r_cam.tgt_y <= '0;
            r_cam.tgt_z <= '0;
            r_focal     <= 8'd80;
        end else if (w_cfg_we) begin
            unique case (w_cfg_idx)
                CFG_CAMERA_X:     r_cam.cam_x <= signed'(i_cfg_data);
                CFG_CAMERA_Y:     r_cam.cam_y <= signed'(i_cfg_data);
                CFG_CAMERA_Z:     r_cam.cam_z <= signed'(i_cfg_data);
                CFG_TARGET_X:     r_cam.tgt_x <= signed'(i_cfg_data);
                CFG_TARGET_Y:     r_cam.tgt_y <= signed'(i_cfg_data);
                CFG_TARGET_Z:     r_cam.tgt_z <= signed'(i_cfg_data);
                CFG_FOCAL_LENGTH: r_focal     <= i_cfg_data[FW-1:0];
                default: begin
                end
            endcase
        end
    end

    // camera basis, rebuilt after reset and after every config write
    lpp_basis u_basis (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_cfg_we),
        .i_cam     (r_cam),
        .o_busy    (w_basis_busy),
        .o_basis   (w_b)
    );

    assign o_busy   = w_basis_busy;
    assign w_accept = i_start & ~w_basis_busy;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_done <= 1'b0;
            for (int j = 0; j <= QB; j++) begin
                r_dv[j] <= 1'b0;
            end
        end else begin
            r_v0    <= w_accept;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_dv[0] <= r_v4;
            for (int j = 0; j < QB; j++) begin
                r_dv[j+1] <= r_dv[j];
            end
            r_done  <= r_dv[QB];
        end
    end

    // magnitudes for floor division, negative side biased by depth - 1
    assign w_magx = r_nx[NW-1] ? NW'(-r_nx) : NW'(r_nx);
    assign w_magy = r_ny[NW-1] ? NW'(-r_ny) : NW'(r_ny);
    assign w_dk   = MW'(r_d4) << QB;

    // restoring divide, one quotient bit per stage
    always_comb begin
        n_lx[0] = r_lx[0];
        n_ly[0] = r_ly[0];
        for (int j = 0; j < QB; j++) begin
            n_lx[j+1] = r_lx[j];
            n_ly[j+1] = r_ly[j];
            if (r_lx[j].rem >= (MW'(r_dd[j]) << (QB - 1 - j))) begin
                n_lx[j+1].rem = r_lx[j].rem - (MW'(r_dd[j]) << (QB - 1 - j));
                n_lx[j+1].q[QB-1-j] = 1'b1;
            end
            if (r_ly[j].rem >= (MW'(r_dd[j]) << (QB - 1 - j))) begin
                n_ly[j+1].rem = r_ly[j].rem - (MW'(r_dd[j]) << (QB - 1 - j));
                n_ly[j+1].q[QB-1-j] = 1'b1;
            end
        end
    end

    // bounds check and screen coordinates
    assign w_qx  = r_lx[QB].q;
    assign w_qy  = r_ly[QB].q;
    assign w_inx = !r_lx[QB].ovf && (r_lx[QB].neg ? (SXW'(w_qx) <= SXW'(HW))
                                                 : (SXW'(w_qx) < SXW'(SCREEN_WIDTH - HW)));
    assign w_iny = !r_ly[QB].ovf && (r_ly[QB].neg ? (SXW'(w_qy) <= SXW'(HH))
                                                 : (SXW'(w_qy) < SXW'(SCREEN_HEIGHT - HH)));
    assign w_vis = r_dpos[QB] & w_inx & w_iny;
    assign w_sx  = r_lx[QB].neg ? SXW'(HW) - SXW'(w_qx) : SXW'(HW) + SXW'(w_qx);
    assign w_sy  = r_ly[QB].neg ? SXW'(HH) - SXW'(w_qy) : SXW'(HH) + SXW'(w_qy);

    // pipeline payload
    always_ff @(posedge i_clk) begin
        // point relative to camera
        r_px <= PW'(i_point_x) - PW'(r_cam.cam_x);
        r_py <= PW'(i_point_y) - PW'(r_cam.cam_y);
        r_pz <= PW'(i_point_z) - PW'(r_cam.cam_z);
        // products with the basis
        r_m[0] <= r_px * w_b.rx;
        r_m[1] <= r_pz * w_b.rz;
        r_m[2] <= r_px * w_b.ux;
        r_m[3] <= r_py * w_b.uy;
        r_m[4] <= r_pz * w_b.uz;
        r_m[5] <= r_px * w_b.fx;
        r_m[6] <= r_py * w_b.fy;
        r_m[7] <= r_pz * w_b.fz;
        // dot products
        r_tx <= TW'(r_m[0]) + TW'(r_m[1]);
        r_ty <= TW'(r_m[2]) + TW'(r_m[3]) + TW'(r_m[4]);
        r_tz <= TW'(r_m[5]) + TW'(r_m[6]) + TW'(r_m[7]);
        // perspective numerators
        r_nx   <= r_tx * signed'({1'b0, r_focal});
        r_ny   <= r_ty * signed'({1'b0, r_focal});
        r_d3   <= unsigned'(r_tz);
        r_pos3 <= (r_tz > 0);
        // biased magnitudes
        r_mx   <= MW'(w_magx) + (r_nx[NW-1] ? MW'(r_d3) - MW'(1) : '0);
        r_my   <= MW'(w_magy) + (r_ny[NW-1] ? MW'(r_d3) - MW'(1) : '0);
        r_negx <= r_nx[NW-1];
        r_negy <= r_ny[NW-1];
        r_d4   <= r_d3;
        r_pos4 <= r_pos3;
        // quotient range check
        r_lx[0].rem <= r_mx;
        r_lx[0].q   <= '0;
        r_lx[0].neg <= r_negx;
        r_lx[0].ovf <= (r_mx >= w_dk);
        r_ly[0].rem <= r_my;
        r_ly[0].q   <= '0;
        r_ly[0].neg <= r_negy;
        r_ly[0].ovf <= (r_my >= w_dk);
        r_dd[0]     <= r_d4;
        r_dpos[0]   <= r_pos4;
        // divide stages
        for (int j = 0; j < QB; j++) begin
            r_lx[j+1]   <= n_lx[j+1];
            r_ly[j+1]   <= n_ly[j+1];
            r_dd[j+1]   <= r_dd[j];
            r_dpos[j+1] <= r_dpos[j];
        end
        // result
        r_vis <= w_vis;
        r_sx  <= w_vis ? w_sx[6:0] : '0;
        r_sy  <= w_vis ? w_sy[5:0] : '0;
    end

    assign o_done     = r_done;
    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;
    assign o_visible  = r_vis;

endmodule

### test/lpp_projection_checker.sv
// projection checker: predicts each item's pixel and compares it with the block's results
`timescale 1ns / 100ps

module lpp_projection_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic signed [15:0] i_point_z,
    input  logic               i_done,
    input  logic [6:0]         i_screen_x,
    input  logic [5:0]         i_screen_y,
    input  logic               i_visible,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import lpp_pkg::*;

    typedef struct packed {
        logic [6:0] sx;
        logic [5:0] sy;
        logic       vis;
    } t_pixel;

    localparam longint UNIT_MAX    = 32767;
    localparam longint RIGHT_MIN_SQ = 1073;

    // shadow copy of the camera registers
    longint cam_x, cam_y, cam_z, tgt_x, tgt_y, tgt_z, focal;
    t_pixel expected_pixels[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > UNIT_MAX) return UNIT_MAX;
        if (v < -UNIT_MAX) return -UNIT_MAX;
        return v;
    endfunction

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q -= 1;
        return q;
    endfunction

    // camera basis from the registers, then the perspective divide
    function automatic t_pixel project_point(longint ptx, longint pty, longint ptz);
        longint dx, dy, dz, fx, fy, fz, rx, rz, ux, uy, uz, r;
        longint px, py, pz, tx, ty, tz, sx, sy;
        longint unsigned s;
        t_pixel p;
        dx = tgt_x - cam_x;
        dy = tgt_y - cam_y;
        dz = tgt_z - cam_z;
        s = dx * dx + dy * dy + dz * dz;
        if (s != 0) begin
            r = longint'(int_sqrt(s << 20));
            fx = clamp_unit((dx * 33554432) / r);
            fy = clamp_unit((dy * 33554432) / r);
            fz = clamp_unit((dz * 33554432) / r);
        end else begin
            fx = 0;
            fy = 0;
            fz = UNIT_MAX;
        end
        rx = -fz;
        rz = fx;
        s = fx * fx + fz * fz;
        // right left unnormalized when forward is nearly vertical
        if (s > RIGHT_MIN_SQ) begin
            r = longint'(int_sqrt(s << 20));
            rx = clamp_unit((-fz * 33554432) / r);
            rz = clamp_unit((fx * 33554432) / r);
        end
        ux = clamp_unit((-rz * fy) / 32768);
        uy = clamp_unit((rz * fx - rx * fz) / 32768);
        uz = clamp_unit((rx * fy) / 32768);
        px = ptx - cam_x;
        py = pty - cam_y;
        pz = ptz - cam_z;
        tx = px * rx + pz * rz;
        ty = px * ux + py * uy + pz * uz;
        tz = px * fx + py * fy + pz * fz;
        p = '0;
        if (tz > 0) begin
            sx = floor_quot(tx * focal, tz) + SCREEN_WIDTH_DEF / 2;
            sy = floor_quot(ty * focal, tz) + SCREEN_HEIGHT_DEF / 2;
            if (sx >= 0 && sx < SCREEN_WIDTH_DEF && sy >= 0 && sy < SCREEN_HEIGHT_DEF) begin
                p.sx  = sx[6:0];
                p.sy  = sy[5:0];
                p.vis = 1'b1;
            end
        end
        return p;
    endfunction

    assign o_pending = expected_pixels.size();

    // track config, predict accepted items, compare strobed results
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            cam_x = 0; cam_y = 0; cam_z = 9600;
            tgt_x = 0; tgt_y = 0; tgt_z = 0;
            focal = 80;
            expected_pixels.delete();
            o_fail_count = 0;
        end else begin
            if (i_done) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: result with no item pending: x=%0d y=%0d vis=%0b",
                             $time, i_screen_x, i_screen_y, i_visible);
                    o_fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want.sx !== i_screen_x) begin
                        $display("%0t: screen_x expected %0d actual %0d",
                                 $time, want.sx, i_screen_x);
                        o_fail_count++;
                    end
                    if (want.sy !== i_screen_y) begin
                        $display("%0t: screen_y expected %0d actual %0d",
                                 $time, want.sy, i_screen_y);
                        o_fail_count++;
                    end
                    if (want.vis !== i_visible) begin
                        $display("%0t: visible expected %0b actual %0b",
                                 $time, want.vis, i_visible);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_pixels.push_back(project_point(longint'(i_point_x),
                    longint'(i_point_y), longint'(i_point_z)));
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CAMERA_X:     cam_x = longint'($signed(i_cfg_data));
                    CFG_CAMERA_Y:     cam_y = longint'($signed(i_cfg_data));
                    CFG_CAMERA_Z:     cam_z = longint'($signed(i_cfg_data));
                    CFG_TARGET_X:     tgt_x = longint'($signed(i_cfg_data));
                    CFG_TARGET_Y:     tgt_y = longint'($signed(i_cfg_data));
                    CFG_TARGET_Z:     tgt_z = longint'($signed(i_cfg_data));
                    CFG_FOCAL_LENGTH: focal = longint'(i_cfg_data[7:0]);
                    default: ;
                endcase
            end
        end
    end

endmodule

### test/tb_lookat_perspective_point_projector_unit.sv
// testbench top: directed and random points over several camera setups, with verdict
`timescale 1ns / 100ps

module tb_lookat_perspective_point_projector_unit;
    import lpp_pkg::*;

    localparam logic [2:0] CFG_SPARE = 3'd7;  // index with no register behind it
    localparam int IDLE_LIMIT = 4000;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 120;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic signed [15:0] i_point_x = '0;
    logic signed [15:0] i_point_y = '0;
    logic signed [15:0] i_point_z = '0;
    logic               i_cfg_valid = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               o_busy, o_done, o_visible, o_cfg_ready;
    logic [6:0]         o_screen_x;
    logic [5:0]         o_screen_y;
    int                 fail_count, pending;
    int                 idle_cycles = 0;
    logic [15:0]        tx, ty, tz;
    bit                 gaps_on;

    lookat_perspective_point_projector_unit dut (.*);

    lpp_projection_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .i_done(o_done), .i_screen_x(o_screen_x), .i_screen_y(o_screen_y),
        .i_visible(o_visible), .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #1 i_clk = ~i_clk;

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        do @(posedge i_clk); while (o_busy);
    endtask

    // hold items back until every result is in, then let the pipe empty
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_camera(input logic [15:0] cx, input logic [15:0] cy,
                              input logic [15:0] cz, input logic [15:0] gx,
                              input logic [15:0] gy, input logic [15:0] gz,
                              input logic [15:0] fl);
        drain();
        write_reg(CFG_CAMERA_X, cx);
        write_reg(CFG_CAMERA_Y, cy);
        write_reg(CFG_CAMERA_Z, cz);
        write_reg(CFG_TARGET_X, gx);
        write_reg(CFG_TARGET_Y, gy);
        write_reg(CFG_TARGET_Z, gz);
        write_reg(CFG_FOCAL_LENGTH, fl);
        tx = gx;
        ty = gy;
        tz = gz;
    endtask

    // random offset around the target, scale picked per item
    function automatic logic [15:0] near(input logic [15:0] base);
        int span;
        span = ($urandom_range(0, 2) == 0) ? 64 : (($urandom_range(0, 1) == 0) ? 1024 : 8192);
        return base + 16'($urandom_range(0, 2 * span) - span);
    endfunction

    initial begin
        logic [15:0] cx, cy, cz, gx, gy, gz, fl;
        int kind;
        gaps_on = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx = '0; ty = '0; tz = '0;

        // reset camera: center, extremes, at the camera, behind it, off to the side
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd32767, 16'sd32767, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768, -16'sd32768);
        send_point(16'sd0, 16'sd0, 16'sd9600);
        send_point(16'sd0, 16'sd0, 16'sd20000);
        send_point(16'sd20000, 16'sd0, 16'sd0);
        send_point(16'sd640, -16'sd320, 16'sd64);
        // camera on top of the target falls back to looking along z
        set_camera(16'sd100, -16'sd50, 16'sd300, 16'sd100, -16'sd50, 16'sd300, 16'd80);
        send_point(16'sd100, -16'sd50, 16'sd2000);
        send_point(16'sd500, 16'sd200, 16'sd6000);
        send_point(16'sd100, -16'sd50, -16'sd2000);
        // forward straight down, right stays unnormalized
        set_camera(16'sd0, 16'sd6400, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd255);
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd64, 16'sd0, 16'sd128);
        send_point(16'sd0, 16'sd12800, 16'sd0);
        // zero focal length puts everything in front at the center
        set_camera(16'sd0, 16'sd0, 16'sd9600, 16'sd0, 16'sd0, 16'sd0, 16'hff00);
        send_point(16'sd3000, -16'sd3000, 16'sd0);
        send_point(16'sd0, 16'sd0, 16'sd0);
        // extreme positions, smallest nonzero focal length, write to the spare index
        set_camera(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                   16'sd32767, 16'd1);
        write_reg(CFG_SPARE, 16'hffff);
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd32767, 16'sd32767, 16'sd32767);
        send_point(-16'sd32768, 16'sd32767, -16'sd32768);

        // random camera setups, each with a burst of points
        for (int ph = 0; ph < PHASES; ph++) begin
            kind = $urandom_range(0, 4);
            cx = 16'($urandom); cy = 16'($urandom); cz = 16'($urandom);
            gx = 16'($urandom); gy = 16'($urandom); gz = 16'($urandom);
            case (kind)
                0: begin
                    cx = cx >>> 3; cy = cy >>> 3; cz = cz >>> 3;
                    gx = gx >>> 3; gy = gy >>> 3; gz = gz >>> 3;
                end
                2: begin
                    gx = cx; gy = cy; gz = cz;
                end
                3: begin
                    gx = cx + 16'($urandom_range(0, 2)); gz = cz;
                end
                4: begin
                    cx = 16'h8000; cy = 16'h7fff; cz = 16'h8000;
                    gx = 16'h7fff; gy = 16'h8000; gz = 16'h7fff;
                end
                default: ;
            endcase
            case ($urandom_range(0, 4))
                0: fl = 16'd0;
                1: fl = 16'd1;
                2: fl = 16'd255;
                default: fl = 16'($urandom);
            endcase
            set_camera(cx, cy, cz, gx, gy, gz, fl);
            if (ph == 3) write_reg(CFG_SPARE, 16'($urandom));
            gaps_on = (ph % 3) != 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 9) < 7)
                    send_point(near(tx), near(ty), near(tz));
                else
                    send_point(16'($urandom), 16'($urandom), 16'($urandom));
            end
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
sv/lpp_pkg.sv
sv/lpp_basis.sv
sv/lookat_perspective_point_projector_unit.sv
test/lpp_projection_checker.sv
test/tb_lookat_perspective_point_projector_unit.sv
